[sv/waveform_generator_with_noise_defines.svh]
// Assertion macros for the waveform generator RTL.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef WAVEFORM_GENERATOR_WITH_NOISE_DEFINES_SVH
`define WAVEFORM_GENERATOR_WITH_NOISE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WGN_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define WGN_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wgn_pkg.sv]
// Shared types, codes, constants and the quarter-wave sine table.
// No dependencies; imported by all waveform generator modules but wgn_ram.
`default_nettype none

package wgn_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned NUM_MODES = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned AMP_W    = 7;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned DRAW_W   = 16;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned BASE_W   = 8;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned PROD_W   = 13;
  localparam int unsigned BOUND_W  = 7;
  localparam int unsigned NOISE_W  = 7;
  localparam int unsigned DEG_W    = 9;
  localparam int unsigned ROM_IDX_W = 7;
  localparam int unsigned SINE_FRAC = 15;

  localparam logic [MODE_W-1:0] MODE_CONST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RAMP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_PCT = 2'd2;

  localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;

  localparam logic [DEG_W-1:0] DEG_QTR   = 9'd90;
  localparam logic [DEG_W-1:0] DEG_HALF  = 9'd180;
  localparam logic [DEG_W-1:0] DEG_3QTR  = 9'd270;
  localparam logic [DEG_W-1:0] DEG_FULL  = 9'd360;
  localparam logic [DEG_W-1:0] DEG_LAST  = 9'd359;

  // floor(x / 100) = (x * 5243) >> 19 for x < 8192
  localparam logic [PROD_W-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned       RECIP_SHIFT = 19;

  localparam logic [ROM_IDX_W-1:0] ROM_LAST = 7'd90;

  localparam logic [MAG_W-1:0] SINE_ROM [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  typedef struct packed {
    logic                     sel_sine;
    logic                     neg;
    logic [MAG_W-1:0]         mag;
    logic signed [BASE_W-1:0] base;
  } wave_t;

  typedef struct packed {
    logic [DRAW_W-1:0] draw;
    logic              add;
    logic [PROD_W-1:0] prod;
  } noise_a_t;

  typedef struct packed {
    logic [DRAW_W-1:0]  draw;
    logic               add;
    logic [BOUND_W-1:0] bound;
  } noise_b_t;

  function automatic logic [AMP_W-1:0] amp_mag(input logic signed [AMP_W-1:0] a);
    logic signed [AMP_W-1:0] n;
    n = -a;
    return a[AMP_W-1] ? n : a;
  endfunction

  function automatic logic [MAG_W-1:0] sine_q15(input logic [ROM_IDX_W-1:0] idx);
    logic [MAG_W-1:0] m;
    m = '0;
    if (idx <= ROM_LAST) begin
      m = SINE_ROM[idx];
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[sv/wgn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wgn_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[sv/wgn_state.sv]
// Per-mode counter state: RAM read-modify-write with write forwarding.
// Depends on wgn_pkg and wgn_ram; produces the base wave term.
`default_nettype none
`include "waveform_generator_with_noise_defines.svh"

module wgn_state import wgn_pkg::*; #(
  parameter int unsigned PHASE_MAX   = 360,
  parameter int unsigned SQUARE_HALF = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    rd_en_i,
  input  logic [MODE_W-1:0]       rd_mode_i,
  input  logic                    a_valid_i,
  input  logic signed [AMP_W-1:0] amp_i,
  output wave_t                   wave_o
);

  localparam int unsigned PW      = $clog2(PHASE_MAX + 2);
  localparam int unsigned SW      = $clog2(2 * SQUARE_HALF + 1);
  localparam int unsigned SINE_EW = PW + DEG_W;
  localparam int unsigned EW0     = (SINE_EW > SW) ? SINE_EW : SW;
  localparam int unsigned EW      = (EW0 > BASE_W) ? EW0 : BASE_W;

  logic [MODE_W-1:0]        mode_a_q;
  logic [NUM_MODES-1:0]     ent_valid_q;
  logic                     byp_valid_q;
  logic [MODE_W-1:0]        byp_addr_q;
  logic [EW-1:0]            byp_data_q;
  logic [EW-1:0]            rd_data;
  logic [EW-1:0]            old_ent;
  logic [EW-1:0]            new_ent;
  logic                     wr_en;
  logic                     wrap;
  logic [PW-1:0]            phase_old;
  logic [PW-1:0]            phase_cur;
  logic [PW-1:0]            phase_nxt;
  logic [DEG_W-1:0]         deg_old;
  logic [DEG_W-1:0]         deg_cur;
  logic [DEG_W-1:0]         deg_nxt;
  logic [DEG_W-1:0]         deg_idx;
  logic                     quad_neg;
  logic [SW-1:0]            sq_nxt;
  logic signed [BASE_W-1:0] amp_ext;
  logic signed [BASE_W-1:0] amag_ext;
  logic signed [BASE_W-1:0] ramp_old;
  logic signed [BASE_W-1:0] ramp_cur;
  logic signed [BASE_W-1:0] ramp_nxt;
  wave_t                    wave_d;
  wave_t                    wave_q;

  assign wr_en = a_valid_i && adv_i && (mode_a_q != MODE_CONST);

  wgn_ram #(
    .DATA_W(EW),
    .DEPTH (NUM_MODES)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(mode_a_q),
    .wr_data_i(new_ent),
    .rd_en_i  (rd_en_i),
    .rd_addr_i(rd_mode_i),
    .rd_data_o(rd_data)
  );

  always_comb begin
    if (byp_valid_q && (byp_addr_q == mode_a_q)) begin
      old_ent = byp_data_q;
    end else if (ent_valid_q[mode_a_q]) begin
      old_ent = rd_data;
    end else begin
      old_ent = '0;
    end
  end

  assign amp_ext  = BASE_W'(amp_i);
  assign amag_ext = signed'({1'b0, amp_mag(amp_i)});

  always_comb begin
    phase_old = old_ent[PW-1:0];
    deg_old   = old_ent[SINE_EW-1:PW];
    wrap      = phase_old > PW'(PHASE_MAX);
    phase_cur = wrap ? '0 : phase_old;
    deg_cur   = wrap ? '0 : deg_old;
    phase_nxt = phase_cur + 1'b1;
    deg_nxt   = (deg_cur == DEG_LAST) ? '0 : deg_cur + 1'b1;

    if (deg_cur <= DEG_QTR) begin
      deg_idx  = deg_cur;
      quad_neg = 1'b0;
    end else if (deg_cur <= DEG_HALF) begin
      deg_idx  = DEG_HALF - deg_cur;
      quad_neg = 1'b0;
    end else if (deg_cur <= DEG_3QTR) begin
      deg_idx  = deg_cur - DEG_HALF;
      quad_neg = 1'b1;
    end else begin
      deg_idx  = DEG_FULL - deg_cur;
      quad_neg = 1'b1;
    end

    sq_nxt   = old_ent[SW-1:0] + 1'b1;
    ramp_old = signed'(old_ent[BASE_W-1:0]);
    ramp_cur = (ramp_old < -amag_ext) ? amag_ext : ramp_old;
    ramp_nxt = ramp_cur - 8'sd1;

    new_ent         = '0;
    wave_d.sel_sine = 1'b0;
    wave_d.neg      = quad_neg ^ amp_i[AMP_W-1];
    wave_d.mag      = sine_q15(deg_idx[ROM_IDX_W-1:0]);
    wave_d.base     = amp_ext;

    unique case (mode_a_q)
      MODE_CONST: begin
        wave_d.base = amp_ext;
      end
      MODE_SINE: begin
        new_ent[PW-1:0]      = phase_nxt;
        new_ent[SINE_EW-1:PW] = deg_nxt;
        wave_d.sel_sine      = 1'b1;
      end
      MODE_SQUARE: begin
        if (sq_nxt < SW'(SQUARE_HALF)) begin
          wave_d.base     = amp_ext;
          new_ent[SW-1:0] = sq_nxt;
        end else if (sq_nxt < SW'(2 * SQUARE_HALF)) begin
          wave_d.base     = -amp_ext;
          new_ent[SW-1:0] = sq_nxt;
        end else begin
          wave_d.base     = '0;
          new_ent[SW-1:0] = '0;
        end
      end
      MODE_RAMP: begin
        wave_d.base         = ramp_cur;
        new_ent[BASE_W-1:0] = ramp_nxt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      byp_valid_q <= 1'b0;
    end else if (wr_en) begin
      ent_valid_q[mode_a_q] <= 1'b1;
      byp_valid_q           <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mode_a_q <= rd_mode_i;
    end
    if (wr_en) begin
      byp_addr_q <= mode_a_q;
      byp_data_q <= new_ent;
    end
    if (adv_i) begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

  `WGN_ASSERT_IMP(a_deg_range, (wr_en && (mode_a_q == MODE_SINE)), (deg_nxt < DEG_FULL), "sine degree out of range")
  `WGN_ASSERT_IMP(a_square_range, (wr_en && (mode_a_q == MODE_SQUARE)), (new_ent[SW-1:0] < SW'(2 * SQUARE_HALF)), "square count out of range")
  `WGN_ASSERT_IMP(a_ramp_floor, (wr_en && (mode_a_q == MODE_RAMP)), (ramp_nxt >= -amag_ext - 8'sd1), "ramp below reload floor")

endmodule

`default_nettype wire

[sv/wgn_mix.sv]
// Sine scaling, noise bound, noise term and saturating sum.
// Depends on wgn_pkg.
`default_nettype none

module wgn_mix import wgn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       adv_i,
  input  noise_a_t                   noise_i,
  input  wave_t                      wave_i,
  input  logic signed [AMP_W-1:0]    amp_i,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  localparam int unsigned BPROD_W = 2 * PROD_W;
  localparam int unsigned SPROD_W = AMP_W + MAG_W;
  localparam int unsigned NPROD_W = DRAW_W + BOUND_W;
  localparam int unsigned SUM_W   = BASE_W + 2;

  logic [BPROD_W-1:0]        bprod;
  noise_b_t                  noise_d;
  noise_b_t                  noise_q;
  logic [SPROD_W-1:0]        sprod;
  logic [BASE_W-1:0]         sine_mag;
  logic signed [BASE_W-1:0]  base;
  logic [BOUND_W-1:0]        bound_p1;
  logic [NPROD_W-1:0]        nprod;
  logic [NOISE_W-1:0]        noise;
  logic signed [SUM_W-1:0]   noise_ext;
  logic signed [SUM_W-1:0]   sum;

  always_comb begin
    bprod         = BPROD_W'(noise_i.prod) * BPROD_W'(RECIP_100);
    noise_d.draw  = noise_i.draw;
    noise_d.add   = noise_i.add;
    noise_d.bound = bprod[RECIP_SHIFT +: BOUND_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      noise_q <= noise_d;
    end
  end

  always_comb begin
    sprod    = SPROD_W'(amp_mag(amp_i)) * SPROD_W'(wave_i.mag);
    sine_mag = sprod[SINE_FRAC +: BASE_W];
    if (wave_i.sel_sine) begin
      base = wave_i.neg ? -signed'(sine_mag) : signed'(sine_mag);
    end else begin
      base = wave_i.base;
    end

    bound_p1  = noise_q.bound + 1'b1;
    nprod     = NPROD_W'(noise_q.draw) * NPROD_W'(bound_p1);
    noise     = nprod[DRAW_W +: NOISE_W];
    noise_ext = SUM_W'(signed'({1'b0, noise}));
    sum       = noise_q.add ? SUM_W'(base) + noise_ext : SUM_W'(base) - noise_ext;

    if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
      sample_o = sum[SAMPLE_W-1:0];
    end else begin
      sample_o = sum[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[sv/waveform_generator_with_noise.sv]
// Pipeline: 3 register stages (A, B, out) from an input transfer to its sample on the output.
// Throughput: one sample per cycle while the output is not stalled; the per-mode counter RAM
// is read at transfer and written back as the item leaves stage A, with the last write forwarded.
// Reset: config goes to mode constant, amplitude 0, noise 50 percent; all
// counters read as zero through per-entry valid bits, no clearing pass.
`default_nettype none
`include "waveform_generator_with_noise_defines.svh"

module waveform_generator_with_noise import wgn_pkg::*; #(
  parameter int unsigned PHASE_MAX   = 360,
  parameter int unsigned SQUARE_HALF = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [DRAW_W-1:0]          noise_draw_i,
  input  logic                       sign_draw_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i
);

  logic [MODE_W-1:0]          mode_q;
  logic signed [AMP_W-1:0]    amp_q;
  logic [PCT_W-1:0]           pct_q;
  logic                       adv;
  logic                       accept;
  logic                       a_valid_q;
  logic                       b_valid_q;
  logic                       out_valid_q;
  noise_a_t                   noise_a_d;
  noise_a_t                   noise_a_q;
  wave_t                      wave_b;
  logic signed [SAMPLE_W-1:0] sample_b;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  assign adv         = !out_valid_q || !out_stall_i;
  assign accept      = in_valid_i && adv;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CONST;
      amp_q  <= '0;
      pct_q  <= PCT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:      mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_AMPLITUDE: amp_q  <= signed'(cfg_data_i[AMP_W-1:0]);
        CFG_NOISE_PCT: pct_q  <= cfg_data_i[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= accept;
      b_valid_q   <= a_valid_q;
      out_valid_q <= b_valid_q;
    end
  end

  always_comb begin
    noise_a_d.draw = noise_draw_i;
    noise_a_d.add  = sign_draw_i;
    noise_a_d.prod = PROD_W'(amp_mag(amp_q)) * PROD_W'(pct_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      noise_a_q    <= noise_a_d;
      out_sample_q <= sample_b;
    end
  end

  wgn_state #(
    .PHASE_MAX  (PHASE_MAX),
    .SQUARE_HALF(SQUARE_HALF)
  ) u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .rd_en_i  (accept),
    .rd_mode_i(mode_q),
    .a_valid_i(a_valid_q),
    .amp_i    (amp_q),
    .wave_o   (wave_b)
  );

  wgn_mix u_mix (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .noise_i (noise_a_q),
    .wave_i  (wave_b),
    .amp_i   (amp_q),
    .sample_o(sample_b)
  );

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;

  `WGN_ASSERT_NXT(a_accept_fill, accept, a_valid_q, "accepted transfer lost at stage A")
  `WGN_ASSERT_NXT(a_stage_b, (a_valid_q && adv), b_valid_q, "stage A item lost")
  `WGN_ASSERT_NXT(a_stage_out, (b_valid_q && adv), out_valid_q, "stage B item lost")

endmodule

`default_nettype wire

[dv/waveform_generator_with_noise_tb.sv]
// Testbench for waveform_generator_with_noise: a directed table, then random register
// settings and ticks, checked against a predictor in this file or the table's known values.
// Depends on wgn_pkg and the RTL in sv/.
`default_nettype none

module waveform_generator_with_noise_tb import wgn_pkg::*; ();

  localparam int PHASE_LIMIT     = 360;
  localparam int HALF_PERIOD     = 10;
  localparam int DEG_TURN        = 360;
  localparam int RANDOM_TICKS    = 1425;
  localparam int SINE_RUN        = 400;
  localparam int LONG_HOLD       = 300;
  localparam int LONG_HOLD_AFTER = 200;
  localparam int SETTLE_CYCLES   = 6;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int MAX_REPORTS     = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef enum logic [1:0] {ROW_WRITE, ROW_TICK, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_W-1:0]            val;
    logic [DRAW_W-1:0]           draw;
    logic                        add;
    logic signed [SAMPLE_W-1:0]  want;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [DRAW_W-1:0]          noise_draw_i;
  logic                       sign_draw_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_W-1:0]           cfg_data_i;

  waveform_generator_with_noise DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .noise_draw_i (noise_draw_i),
    .sign_draw_i  (sign_draw_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_o     (sample_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int quarter_wave [0:90] = '{
        0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
     5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  logic [MODE_W-1:0] cur_mode   = MODE_CONST;
  int                cur_amp    = 0;
  int                cur_pct    = 50;
  int                phase_deg  = 0;
  int                square_cnt = 0;
  int                ramp_lvl   = 0;

  logic signed [SAMPLE_W-1:0] expected_q [$];
  logic signed [SAMPLE_W-1:0] want_s;
  int  errors       = 0;
  int  samples_seen = 0;
  int  ticks_sent   = 0;
  int  settings     = 0;
  int  idle_cycles  = 0;
  bit  calm_in      = 1'b0;
  bit  calm_out     = 1'b0;
  bit  held_long    = 1'b0;

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
    case (idx)
      CFG_MODE:      cur_mode = val[MODE_W-1:0];
      CFG_AMPLITUDE: cur_amp  = int'($signed(val));
      CFG_NOISE_PCT: cur_pct  = int'(val);
      default:       ;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] next_sample(input logic [DRAW_W-1:0] draw,
                                                             input logic add);
    int amag, base, bound, noise, s, d, mag, prod;
    bit neg;
    amag = (cur_amp < 0) ? -cur_amp : cur_amp;
    base = 0;
    case (cur_mode)
      MODE_CONST: base = cur_amp;
      MODE_SINE: begin
        if (phase_deg > PHASE_LIMIT) phase_deg = 0;
        d   = phase_deg % DEG_TURN;
        neg = 1'b0;
        if (d <= 90) begin
          mag = quarter_wave[d];
        end else if (d <= 180) begin
          mag = quarter_wave[180 - d];
        end else if (d <= 270) begin
          mag = quarter_wave[d - 180];
          neg = 1'b1;
        end else begin
          mag = quarter_wave[DEG_TURN - d];
          neg = 1'b1;
        end
        if (cur_amp < 0) neg = !neg;
        prod = (amag * mag) >> 15;
        base = neg ? -prod : prod;
        phase_deg++;
      end
      MODE_SQUARE: begin
        square_cnt++;
        case (square_cnt / HALF_PERIOD)
          0:       base = cur_amp;
          1:       base = -cur_amp;
          default: begin
            base       = 0;
            square_cnt = 0;
          end
        endcase
      end
      MODE_RAMP: begin
        if (ramp_lvl < -amag) ramp_lvl = amag;
        base = ramp_lvl;
        ramp_lvl--;
      end
    endcase
    bound = (amag * cur_pct) / 100;
    noise = int'((longint'(draw) * longint'(bound + 1)) >> 16);
    s = add ? base + noise : base - noise;
    if (s > 127) s = 127;
    if (s < -128) s = -128;
    return s[SAMPLE_W-1:0];
  endfunction

  function automatic int pause_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DRAW_W-1:0] pick_draw();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return DRAW_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [CFG_W-1:0] pick_amp();
    case ($urandom_range(0, 9))
      0:       return CFG_W'(-64);
      1:       return CFG_W'(63);
      2:       return CFG_W'(-50);
      3:       return CFG_W'(50);
      4:       return '0;
      default: return CFG_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_pct();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_W'(100);
      2:       return CFG_W'(127);
      default: return CFG_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic stim_row_t set_row(input logic [CFG_IDX_W-1:0] idx, input int v);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = CFG_W'(v);
    return r;
  endfunction

  function automatic stim_row_t tick_row(input logic [DRAW_W-1:0] d, input logic s);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_TICK;
    r.draw = d;
    r.add  = s;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [DRAW_W-1:0] d, input logic s,
                                          input int w);
    stim_row_t r;
    r      = tick_row(d, s);
    r.kind = ROW_KNOWN;
    r.want = SAMPLE_W'(w);
    return r;
  endfunction

  task automatic offer_tick(input logic [DRAW_W-1:0] d, input logic s, input bit has_want,
                            input logic signed [SAMPLE_W-1:0] want);
    int gap;
    logic signed [SAMPLE_W-1:0] predicted;
    if ($urandom_range(0, 63) == 0) calm_in = !calm_in;
    gap = pause_len(calm_in);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    noise_draw_i <= d;
    sign_draw_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = next_sample(d, s);
    expected_q.push_back(has_want ? want : predicted);
    ticks_sent++;
  endtask

  task automatic settle();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // check each output transfer against the oldest expected sample
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      samples_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected sample, expected none, actual %0d", $time, sample_o);
      end else begin
        want_s = expected_q.pop_front();
        if (sample_o !== want_s) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want_s,
                     sample_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transfer for %0d cycles, %0d samples outstanding", $time,
               WATCHDOG_CYCLES, expected_q.size());
      $display("waveform_generator_with_noise regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stalls, plus one long hold-off to back the block up
  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) calm_out = !calm_out;
      if (!held_long && samples_seen >= LONG_HOLD_AFTER) begin
        held_long = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        n = pause_len(calm_out);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    stim_row_t         directed_q [$];
    logic [MODE_W-1:0] m;
    int                len;
    int                random_sent;
    bit                first;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    noise_draw_i = '0;
    sign_draw_i  = 1'b0;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset the amplitude is zero, so noise is zero too
    directed_q.push_back(known_row(16'hFFFF, 1'b1, 0));
    directed_q.push_back(known_row(16'h0000, 1'b0, 0));
    directed_q.push_back(set_row(CFG_NOISE_PCT, 0));
    directed_q.push_back(set_row(CFG_AMPLITUDE, 50));
    directed_q.push_back(known_row(16'hFFFF, 1'b1, 50));
    directed_q.push_back(set_row(CFG_AMPLITUDE, -50));
    directed_q.push_back(known_row(16'hFFFF, 1'b0, -50));
    directed_q.push_back(set_row(CFG_NOISE_PCT, 100));
    directed_q.push_back(set_row(CFG_AMPLITUDE, 50));
    directed_q.push_back(known_row(16'hFFFF, 1'b1, 100));
    directed_q.push_back(known_row(16'h0000, 1'b0, 50));
    // extreme amplitudes and out-of-range percent, both saturating
    directed_q.push_back(set_row(CFG_AMPLITUDE, -64));
    directed_q.push_back(set_row(CFG_NOISE_PCT, 127));
    directed_q.push_back(known_row(16'hFFFF, 1'b0, -128));
    directed_q.push_back(set_row(CFG_AMPLITUDE, 63));
    directed_q.push_back(known_row(16'hFFFF, 1'b1, 127));
    // write to the unused index must leave the registers alone
    directed_q.push_back(set_row(CFG_NONE, 127));
    directed_q.push_back(known_row(16'h0000, 1'b1, 63));
    directed_q.push_back(set_row(CFG_MODE, MODE_SINE));
    directed_q.push_back(set_row(CFG_AMPLITUDE, 50));
    directed_q.push_back(set_row(CFG_NOISE_PCT, 0));
    directed_q.push_back(tick_row(16'h1234, 1'b1));
    directed_q.push_back(tick_row(16'h8000, 1'b0));
    directed_q.push_back(tick_row(16'hFFFF, 1'b1));
    directed_q.push_back(set_row(CFG_MODE, MODE_SQUARE));
    directed_q.push_back(tick_row(16'h5555, 1'b0));
    directed_q.push_back(tick_row(16'hAAAA, 1'b1));
    directed_q.push_back(tick_row(16'h0001, 1'b0));
    directed_q.push_back(set_row(CFG_MODE, MODE_RAMP));
    directed_q.push_back(set_row(CFG_AMPLITUDE, 3));
    directed_q.push_back(set_row(CFG_NOISE_PCT, 25));
    repeat (8) directed_q.push_back(tick_row(16'h7FFF, 1'b1));
    // change amplitude in the middle of a ramp
    directed_q.push_back(set_row(CFG_AMPLITUDE, 1));
    repeat (2) directed_q.push_back(tick_row(16'hC000, 1'b0));

    foreach (directed_q[i]) begin
      if (directed_q[i].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_q[i].idx, directed_q[i].val);
      end else begin
        offer_tick(directed_q[i].draw, directed_q[i].add, directed_q[i].kind == ROW_KNOWN,
                   directed_q[i].want);
      end
    end

    random_sent = 0;
    first       = 1'b1;
    while (random_sent < RANDOM_TICKS) begin
      settle();
      if (first) begin
        write_reg(CFG_MODE, CFG_W'(MODE_SINE));
        write_reg(CFG_AMPLITUDE, CFG_W'(63));
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          m = MODE_W'($urandom_range(0, NUM_MODES - 1));
          write_reg(CFG_MODE, CFG_W'(m));
        end
        write_reg(CFG_AMPLITUDE, pick_amp());
      end
      if ($urandom_range(0, 3) != 0) write_reg(CFG_NOISE_PCT, pick_pct());
      if ($urandom_range(0, 9) == 0) write_reg(CFG_NONE, CFG_W'($urandom_range(0, 127)));
      settings++;
      len = first ? SINE_RUN : $urandom_range(5, 80);
      repeat (len) begin
        offer_tick(pick_draw(), 1'($urandom_range(0, 1)), 1'b0, '0);
        random_sent++;
      end
      first = 1'b0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES + 4) @(posedge clk_i);

    $display("ran %0d ticks (%0d directed) over %0d random register settings", ticks_sent,
             ticks_sent - random_sent, settings);
    $display("%0d samples checked, %0d mismatches", samples_seen, errors);
    if (errors == 0) begin
      $display("waveform_generator_with_noise regression: pass");
    end else begin
      $display("waveform_generator_with_noise regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
